### rtl/prct_pkg.sv
package prct_pkg;

	localparam int POS_W = 10;
	localparam int CNT_W = 11;
	localparam int VAL_W = 32;

	typedef struct packed {
		logic                    action;
		logic [POS_W-1:0]        position;
		logic [POS_W-1:0]        range_high;
		logic signed [VAL_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0] even_count;
		logic [CNT_W-1:0] odd_count;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic load_item;
		logic walk_rd;
		logic walk_wr;
		logic qry_rd;
		logic qry_acc;
		logic load_res;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic item_write;
		logic item_query;
		logic item_live;
		logic walk_last;
		logic qry_more;
	} sts_t;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

endpackage

### rtl/prct_ctrl.sv
module prct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  prct_pkg::sts_t     sts,
	output prct_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_QRY_RD,
		ST_QRY_ACC,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   accept;
	logic   res_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign accept    = req_valid && req_ready;
	assign res_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd           = '0;
		cmd.clr_step  = (state_q == ST_CLEAR);
		cmd.load_item = accept;
		cmd.walk_rd   = (state_q == ST_WALK_RD);
		cmd.walk_wr   = (state_q == ST_WALK_WR);
		cmd.qry_rd    = (state_q == ST_QRY_RD);
		cmd.qry_acc   = (state_q == ST_QRY_ACC);
		cmd.load_res  = (state_q == ST_DONE) && res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_res)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (sts.item_write)
							state_q <= ST_WALK_RD;
						else if (sts.item_query)
							state_q <= sts.item_live ? ST_QRY_RD : ST_DONE;
					end
				end
				ST_WALK_RD: state_q <= ST_WALK_WR;
				ST_WALK_WR: begin
					state_q <= sts.walk_last ? ST_IDLE : ST_WALK_RD;
				end
				ST_QRY_RD: state_q <= ST_QRY_ACC;
				ST_QRY_ACC: begin
					state_q <= sts.qry_more ? ST_QRY_RD : ST_DONE;
				end
				ST_DONE: begin
					if (res_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/prct_dp.sv
module prct_dp #(
	parameter int SLOTS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  prct_pkg::in_t  req,
	output prct_pkg::out_t rsp,
	input  prct_pkg::cmd_t cmd,
	output prct_pkg::sts_t sts
);

	localparam int POS_W  = prct_pkg::POS_W;
	localparam int CNT_W  = prct_pkg::CNT_W;
	// slots beyond the position field can never be written
	localparam int EFF    = (SLOTS < (1 << POS_W)) ? SLOTS : (1 << POS_W);
	localparam int LOG    = $clog2(EFF);
	localparam int AW     = LOG + 1;
	localparam int LW     = LOG + 2;
	localparam int LEAVES = 1 << LOG;
	localparam int DEPTH  = 1 << AW;

	typedef struct packed {
		logic [CNT_W-1:0] even;
		logic [CNT_W-1:0] odd;
	} node_t;

	// node 1 is the root, leaves sit at LEAVES + slot
	node_t mem [DEPTH];

	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    idx_q;
	node_t            cnt_q;
	logic [LW-1:0]    l_q;
	logic [LW-1:0]    r_q;
	logic             take_l_q;
	logic             take_r_q;
	node_t            acc_q;
	node_t            rd_a_q;
	node_t            rd_b_q;
	prct_pkg::out_t   rsp_q;

	logic [POS_W-1:0] hi_clamp;
	logic             pos_ok;
	logic             v0;
	node_t            leaf;
	node_t            walk_sum;
	logic [LW-1:0]    r_m1;
	logic [AW-1:0]    ra;
	logic [AW-1:0]    rb;
	logic             we;
	logic [AW-1:0]    wa;
	node_t            wd;

	assign pos_ok   = 32'(req.position) < EFF;
	assign hi_clamp = (32'(req.range_high) >= EFF) ? POS_W'(EFF - 1) : req.range_high;
	assign v0       = req.value[0];
	assign leaf     = '{even: {{(CNT_W-1){1'b0}}, ~v0}, odd: {{(CNT_W-1){1'b0}}, v0}};

	assign walk_sum.even = cnt_q.even + rd_a_q.even;
	assign walk_sum.odd  = cnt_q.odd + rd_a_q.odd;

	assign r_m1 = r_q - LW'(1);
	assign ra   = cmd.walk_rd ? (idx_q ^ AW'(1)) : l_q[AW-1:0];
	assign rb   = r_m1[AW-1:0];

	always_comb begin
		sts            = '0;
		sts.clr_last   = (clr_q == {AW{1'b1}});
		sts.item_write = (req.action == prct_pkg::ACT_WRITE) && pos_ok;
		sts.item_query = (req.action == prct_pkg::ACT_QUERY);
		sts.item_live  = pos_ok && (req.position <= hi_clamp);
		sts.walk_last  = ((idx_q >> 1) == AW'(1));
		sts.qry_more   = (l_q < r_q);
	end

	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.load_item && sts.item_write) begin
			we = 1'b1;
			wa = AW'(LEAVES) + AW'(req.position);
			wd = leaf;
		end else if (cmd.walk_wr) begin
			we = 1'b1;
			wa = idx_q >> 1;
			wd = walk_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr_step)
			clr_q <= clr_q + AW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			idx_q <= AW'(LEAVES) + AW'(req.position);
			cnt_q <= leaf;
			l_q   <= LW'(LEAVES) + LW'(req.position);
			r_q   <= LW'(LEAVES) + LW'(hi_clamp) + LW'(1);
			acc_q <= '0;
		end
		if (cmd.walk_wr) begin
			idx_q <= idx_q >> 1;
			cnt_q <= walk_sum;
		end
		// bottom-up walk over the half-open range [l, r)
		if (cmd.qry_rd) begin
			take_l_q <= l_q[0];
			take_r_q <= r_q[0];
			l_q      <= (l_q + LW'(l_q[0])) >> 1;
			r_q      <= (r_q - LW'(r_q[0])) >> 1;
		end
		if (cmd.qry_acc) begin
			acc_q.even <= acc_q.even + (take_l_q ? rd_a_q.even : CNT_W'(0))
				+ (take_r_q ? rd_b_q.even : CNT_W'(0));
			acc_q.odd  <= acc_q.odd + (take_l_q ? rd_a_q.odd : CNT_W'(0))
				+ (take_r_q ? rd_b_q.odd : CNT_W'(0));
		end
		if (cmd.load_res) begin
			rsp_q.even_count <= acc_q.even;
			rsp_q.odd_count  <= acc_q.odd;
		end
	end

	assign rsp = rsp_q;

endmodule

### rtl/parity_range_count_tree_top.sv
// Even/odd counting segment tree over SLOTS slots (only the first 1024 are reachable through
// the 10-bit position). A write beat sets one slot's parity from bit 0 of value and produces
// no response; a query beat returns the counts of written even and odd slots in
// [position, range_high], range_high clamped to the last slot, zero when the range is empty.
// Tree nodes live in one memory with a write port and two registered read ports. A write
// stores the leaf and then updates each ancestor up to the root, and a query walks up the
// tree from both ends of the range; on each tree level it visits, a read state is followed
// by a combine state, because the memory reads are registered. One beat is worked on at a
// time. The response sits in an output register, so the next request is taken while it
// waits. After reset a clearing pass writes zero to every node, and no request is taken
// until it ends.
module parity_range_count_tree_top #(
	parameter int SLOTS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  prct_pkg::in_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output prct_pkg::out_t rsp
);

	prct_pkg::cmd_t cmd;
	prct_pkg::sts_t sts;

	prct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	prct_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

### rtl/prct_chk.sv
module prct_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input prct_pkg::in_t  req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input prct_pkg::out_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	// the block does not take a request in the cycle after a query
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.action == prct_pkg::ACT_QUERY) |=> !req_ready)
		else $error("request taken right after a query");

	// writes never produce a response
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.action == prct_pkg::ACT_WRITE) && !rsp_valid
		|=> !rsp_valid)
		else $error("response appeared after a write");

	// the request port is closed as reset is released, when the clearing pass starts
	a_clear_first: assert property (@(posedge clk)
		$rose(arst_n) |-> !req_ready)
		else $error("request port open during clearing pass");

endmodule

bind parity_range_count_tree_top prct_chk u_chk (.*);
